// ===== rtl/sesq_pkg.sv =====
// Package with the beat types, character constants and escape table of the string quoter.
`default_nettype none
package sesq_pkg;

	localparam int unsigned MaxBytes = 4;

	localparam logic [7:0] CHAR_QUOTE     = 8'h22;
	localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
	localparam logic [7:0] CHAR_NUL       = 8'h00;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first;
		logic [15:0] capacity;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        last;
		logic [15:0] total_length;
	} out_item_t;

	// Bytes that one input beat produces, slot 0 first.
	typedef struct packed {
		logic [MaxBytes-1:0][7:0] bytes;
		logic [2:0]               len;
		logic                     close;
		logic [15:0]              total;
	} packet_t;

	// Letter that follows the backslash, or zero when the byte passes unchanged.
	function automatic logic [7:0] escape_letter(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			8'h07:   r = 8'h61; // a
			8'h08:   r = 8'h62; // b
			8'h09:   r = 8'h74; // t
			8'h0A:   r = 8'h6E; // n
			8'h0B:   r = 8'h76; // v
			8'h0C:   r = 8'h66; // f
			8'h0D:   r = 8'h72; // r
			8'h1B:   r = 8'h65; // e
			8'h22:   r = CHAR_QUOTE;
			8'h27:   r = 8'h27;
			8'h5C:   r = CHAR_BACKSLASH;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/sesq_stream_if.sv =====
// Valid/ready stream interface carrying one payload per beat.
`default_nettype none
interface sesq_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/sesq_encoder.sv =====
// Literal state and escape logic that turns one input beat into a packet of output bytes.
`default_nettype none
module sesq_encoder (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire sesq_pkg::in_item_t item,
	output sesq_pkg::packet_t      pkt
);
	import sesq_pkg::*;

	logic [15:0] count_q;
	logic [15:0] limit_q;
	logic        open_q;

	logic [15:0] cnt;
	logic [15:0] lim;
	logic        open_nx;

	always_comb begin
		logic [2:0] n;
		logic       done;
		logic [7:0] esc;
		cnt     = count_q;
		lim     = limit_q;
		open_nx = open_q;
		n       = 3'd0;
		done    = 1'b0;
		esc     = escape_letter(item.data_byte);
		pkt     = '0;
		if (item.first) begin
			cnt = '0;
			if (item.capacity <= 16'd2) begin
				lim     = '0;
				open_nx = 1'b0;
				done    = 1'b1;
			end else begin
				lim          = item.capacity - 16'd2;
				open_nx      = 1'b1;
				pkt.bytes[0] = CHAR_QUOTE;
				n            = 3'd1;
				cnt          = 16'd1;
				if (cnt >= lim) begin
					// Capacity three: the literal closes right after it opens.
					cnt          = 16'd2;
					pkt.bytes[1] = CHAR_QUOTE;
					n            = 3'd2;
					pkt.close    = 1'b1;
					pkt.total    = cnt;
					open_nx      = 1'b0;
					done         = 1'b1;
				end
			end
		end
		if (!done && open_nx) begin
			if (item.data_byte == CHAR_NUL) begin
				cnt               = cnt + 16'd1;
				pkt.bytes[n[1:0]] = CHAR_QUOTE;
				n                 = n + 3'd1;
				pkt.close         = 1'b1;
				pkt.total         = cnt;
				open_nx           = 1'b0;
			end else begin
				if (esc != 8'h00) begin
					pkt.bytes[n[1:0]]         = CHAR_BACKSLASH;
					pkt.bytes[n[1:0] + 2'd1]  = esc;
					n                         = n + 3'd2;
					cnt                       = cnt + 16'd2;
				end else begin
					pkt.bytes[n[1:0]] = item.data_byte;
					n                 = n + 3'd1;
					cnt               = cnt + 16'd1;
				end
				if (cnt >= lim) begin
					cnt               = cnt + 16'd1;
					pkt.bytes[n[1:0]] = CHAR_QUOTE;
					n                 = n + 3'd1;
					pkt.close         = 1'b1;
					pkt.total         = cnt;
					open_nx           = 1'b0;
				end
			end
		end
		pkt.len = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			limit_q <= '0;
			open_q  <= 1'b0;
		end else if (accept) begin
			count_q <= cnt;
			limit_q <= lim;
			open_q  <= open_nx;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sesq_serializer.sv =====
// Packet register and output register that send a packet out one byte per beat.
`default_nettype none
module sesq_serializer (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire sesq_pkg::packet_t pkt,
	output logic                  pkt_free,
	sesq_stream_if.source         dst
);
	import sesq_pkg::*;

	packet_t    pkt_s1;
	logic       pkt_valid_s1;
	logic [1:0] idx_q;
	out_item_t  out_q;
	logic       out_valid_q;

	logic out_free;
	logic emit;
	logic end_of_pkt;

	assign out_free   = !out_valid_q || dst.ready;
	assign emit       = pkt_valid_s1 && out_free;
	assign end_of_pkt = emit && ({1'b0, idx_q} + 3'd1 == pkt_s1.len);
	assign pkt_free   = !pkt_valid_s1 || end_of_pkt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_valid_s1 <= 1'b0;
			idx_q        <= '0;
		end else if (load && pkt.len != 3'd0) begin
			pkt_valid_s1 <= 1'b1;
			idx_q        <= '0;
		end else if (end_of_pkt) begin
			pkt_valid_s1 <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pkt_s1 <= pkt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (dst.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_byte     <= pkt_s1.bytes[idx_q];
			out_q.last         <= pkt_s1.close && end_of_pkt;
			out_q.total_length <= (pkt_s1.close && end_of_pkt) ? pkt_s1.total : 16'd0;
		end
	end

	assign dst.valid   = out_valid_q;
	assign dst.payload = out_q;

`ifndef SYNTHESIS
	a_pkt_len: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid_s1 |-> (pkt_s1.len != 3'd0 && pkt_s1.len <= 3'd4))
		else $error("packet register holds an empty or oversized packet");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid_s1 |-> ({1'b0, idx_q} < pkt_s1.len))
		else $error("byte index ran past the end of the packet");
	a_last_quote: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.last) |-> (out_q.out_byte == CHAR_QUOTE))
		else $error("closing beat is not a double quote");
	a_last_total: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.last) |-> (out_q.total_length >= 16'd2))
		else $error("closing beat reports a length below two");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> pkt_free)
		else $error("packet loaded while the previous one is still sending");
`endif

endmodule
`default_nettype wire

// ===== rtl/string_escape_quoter.sv =====
// Top level of the streaming C string literal quoter.
// The src channel takes one source byte per beat, with first marking the
// start of a new string and capacity sampled on that beat. The dst channel
// gives the quoted literal one byte per beat: the opening quote, the body
// with BEL, BS, TAB, LF, VT, FF, CR, ESC, quotes and backslash escaped, and the closing
// quote, which carries last and the total length including both quotes.
// A zero byte closes the literal; so does reaching capacity minus two,
// after which bytes are dropped until the next first beat. A capacity of
// two or less writes nothing.
// Each accepted beat is turned into a packet of zero to four bytes in the
// same cycle it is taken. While the receiver is ready, the packet register
// feeds the output register one byte per cycle; the first result byte is
// valid once it has passed the packet register and the output register.
// An input beat holds the packet register until its last byte moves to the
// output register, and src.ready rises again in that cycle, so beats that
// each yield one byte go through at one per clock while the receiver is ready.
// When the receiver stalls, the output register holds its beat, the packet
// register fills, and src.ready drops until the stall clears.
// Reset clears the open-literal state, the count and the limit, and empties
// both registers; no literal is open afterward.
`default_nettype none
module string_escape_quoter (
	input  wire logic     clk,
	input  wire logic     arst_n,
	sesq_stream_if.sink   src,
	sesq_stream_if.source dst
);
	import sesq_pkg::*;

	packet_t pkt;
	logic    pkt_free;
	logic    accept;

	// The packet register must be empty, or emptying this cycle, to take a beat.
	assign src.ready = pkt_free;
	assign accept    = src.valid && pkt_free;

	sesq_encoder u_encoder (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (src.payload),
		.pkt    (pkt)
	);

	sesq_serializer u_serializer (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.pkt      (pkt),
		.pkt_free (pkt_free),
		.dst      (dst)
	);

endmodule
`default_nettype wire
